FILE: hdl/bswm_pkg.sv
// ----------------------------------------------------------------------------
// bswm_pkg
// Shared types, address-decode constants and helpers for the bank switch
// mapper with IRQ counter.
// ----------------------------------------------------------------------------
`default_nettype none

package bswm_pkg;

    // operation codes
    localparam logic OP_WRITE = 1'b0;
    localparam logic OP_TICK  = 1'b1;

    // 4 KB windows (address bits 15:12)
    localparam logic [3:0] WIN_PRG       = 4'h8;
    localparam logic [3:0] WIN_CTL       = 4'h9;
    localparam logic [3:0] WIN_A000      = 4'hA;
    localparam logic [3:0] WIN_CHR_FIRST = 4'hB;
    localparam logic [3:0] WIN_CHR_LAST  = 4'hE;
    localparam logic [3:0] WIN_IRQ       = 4'hF;

    // register slots within a window
    localparam logic [1:0] SLOT_0 = 2'd0;
    localparam logic [1:0] SLOT_1 = 2'd1;
    localparam logic [1:0] SLOT_2 = 2'd2;
    localparam logic [1:0] SLOT_3 = 2'd3;

    // IRQ counter constants
    localparam logic        [8:0] COUNT_FIRE      = 9'h0FF;
    localparam logic        [8:0] COUNT_SAT       = 9'h100;
    localparam logic signed [9:0] PRESCALE_START  = 10'sd341;
    localparam logic signed [9:0] PRESCALE_STEP   = 10'sd3;
    localparam logic signed [9:0] PRESCALE_FLOOR  = -10'sd1;

    localparam logic [7:0] LAST_PRG_RESET = 8'd31;
    localparam logic [4:0] A000_RESET     = 5'd1;

    typedef struct packed {
        logic       hit;
        logic [1:0] slot;
    } t_slot_dec;

    typedef struct packed {
        logic       prg_wr;
        logic       mirror_wr;
        logic       swap_wr;
        logic       a000_wr;
        logic       chr_wr;
        logic       chr_hi;
        logic [2:0] chr_idx;
        logic [7:0] data;
    } t_map_cmd;

    typedef struct packed {
        logic       tick;
        logic       reload_lo;
        logic       reload_hi;
        logic       ctrl;
        logic       ack;
        logic [7:0] data;
    } t_irq_cmd;

    typedef struct packed {
        logic [7:0]      prg_select;
        logic            swap;
        logic [4:0]      a000;
        logic [7:0][7:0] chr;
        logic [1:0]      mirror;
    } t_map_state;

    // only a handful of low-address patterns select a register
    function automatic t_slot_dec decode_slot(input logic [11:0] low);
        t_slot_dec d;
        d.hit  = 1'b1;
        d.slot = SLOT_0;
        unique case (low)
            12'h000:          d.slot = SLOT_0;
            12'h001, 12'h004: d.slot = SLOT_1;
            12'h002, 12'h008: d.slot = SLOT_2;
            12'h003, 12'h00C: d.slot = SLOT_3;
            default:          d.hit  = 1'b0;
        endcase
        return d;
    endfunction

endpackage

`default_nettype wire

FILE: hdl/bswm_if.sv
// ----------------------------------------------------------------------------
// bswm_if
// Valid/ready channels of the mapper: CPU items in, bank mapping out, and
// the configuration write channel.
// ----------------------------------------------------------------------------
`default_nettype none

interface bswm_in_if;
    logic        valid;
    logic        ready;
    logic        operation;
    logic [15:0] address;
    logic [7:0]  write_data;

    modport source (output valid, output operation, output address,
                    output write_data, input ready);
    modport sink   (input valid, input operation, input address,
                    input write_data, output ready);
endinterface

interface bswm_out_if;
    logic        valid;
    logic        ready;
    logic [7:0]  prg_bank_8000;
    logic [4:0]  prg_bank_a000;
    logic [7:0]  prg_bank_c000;
    logic [63:0] chr_banks_packed;
    logic [1:0]  mirroring;
    logic        irq_line;

    modport source (output valid, output prg_bank_8000, output prg_bank_a000,
                    output prg_bank_c000, output chr_banks_packed,
                    output mirroring, output irq_line, input ready);
    modport sink   (input valid, input prg_bank_8000, input prg_bank_a000,
                    input prg_bank_c000, input chr_banks_packed,
                    input mirroring, input irq_line, output ready);
endinterface

interface bswm_cfg_if;
    logic       valid;
    logic       ready;
    logic [7:0] data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

`default_nettype wire

FILE: hdl/bank_switch_mapper_with_irq_counter_unit.sv
// ----------------------------------------------------------------------------
// bank_switch_mapper_with_irq_counter_unit
// Bank switch mapper with scanline/cycle IRQ counter, one word per clock while the output is not stalled.
// ----------------------------------------------------------------------------
// Each input word (CPU write or CPU clock tick) is captured in an input
// register, decoded and applied to the bank and IRQ registers in one pass,
// and the resulting mapping plus IRQ line lands in a result register; one
// word per clock is sustained while the output is not stalled. The input
// register doubles as a skid stage, so one more word is taken while a
// result waits. The last-PRG-bank register (reset 31) is written through
// the configuration channel, which is always ready.
`default_nettype none

module bank_switch_mapper_with_irq_counter_unit
    import bswm_pkg::*;
(
    input  wire logic  i_clk,
    input  wire logic  i_rst_n,
    bswm_in_if.sink    i_in,
    bswm_cfg_if.sink   i_cfg,
    bswm_out_if.source o_out
);

    logic        r_in_valid;
    logic        r_op;
    logic [15:0] r_addr;
    logic [7:0]  r_data;
    logic [7:0]  r_last_prg;

    logic        r_out_valid;
    logic [7:0]  r_prg_8000;
    logic [4:0]  r_prg_a000;
    logic [7:0]  r_prg_c000;
    logic [63:0] r_chr;
    logic [1:0]  r_mirror;
    logic        r_irq;

    logic        w_accept;
    logic        w_advance;
    logic        w_step;
    t_map_cmd    w_map_cmd;
    t_irq_cmd    w_irq_cmd;
    t_map_state  w_map_next;
    logic        w_pending_next;
    logic [7:0]  w_sel;
    logic [7:0]  w_second_last;

    assign w_advance  = !r_out_valid || o_out.ready;
    assign i_in.ready = !r_in_valid || w_advance;
    assign w_accept   = i_in.valid && i_in.ready;
    assign w_step     = r_in_valid && w_advance;
    assign i_cfg.ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
            r_last_prg <= LAST_PRG_RESET;
        end else begin
            if (w_accept) begin
                r_in_valid <= 1'b1;
            end else if (w_advance) begin
                r_in_valid <= 1'b0;
            end
            if (i_cfg.valid) begin
                r_last_prg <= i_cfg.data;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_op   <= i_in.operation;
            r_addr <= i_in.address;
            r_data <= i_in.write_data;
        end
    end

    bswm_decode u_decode (
        .i_op      (r_op),
        .i_addr    (r_addr),
        .i_data    (r_data),
        .o_map_cmd (w_map_cmd),
        .o_irq_cmd (w_irq_cmd)
    );

    bswm_banks u_banks (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_step  (w_step),
        .i_cmd   (w_map_cmd),
        .o_next  (w_map_next)
    );

    bswm_irq u_irq (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_step         (w_step),
        .i_cmd          (w_irq_cmd),
        .o_next_pending (w_pending_next)
    );

    assign w_sel         = {3'b000, w_map_next.prg_select[4:0]};
    assign w_second_last = r_last_prg + 8'hFF;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_advance) begin
            r_out_valid <= r_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_step) begin
            r_prg_8000 <= w_map_next.swap ? w_second_last : w_sel;
            r_prg_c000 <= w_map_next.swap ? w_sel : w_second_last;
            r_prg_a000 <= w_map_next.a000;
            r_chr      <= w_map_next.chr;
            r_mirror   <= w_map_next.mirror;
            r_irq      <= w_pending_next;
        end
    end

    assign o_out.valid            = r_out_valid;
    assign o_out.prg_bank_8000    = r_prg_8000;
    assign o_out.prg_bank_a000    = r_prg_a000;
    assign o_out.prg_bank_c000    = r_prg_c000;
    assign o_out.chr_banks_packed = r_chr;
    assign o_out.mirroring        = r_mirror;
    assign o_out.irq_line         = r_irq;

`ifndef NO_ASSERTIONS
    a_accept_fills: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_accept |=> r_in_valid)
        else $error("accepted word not held in input register");

    a_step_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_step |=> r_out_valid)
        else $error("applied word produced no result");

    a_skid_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_in_valid && !w_advance) |=> (r_in_valid && $stable(r_addr) && $stable(r_op)))
        else $error("pending input word lost while output stalled");
`endif

endmodule

`default_nettype wire

FILE: hdl/bswm_decode.sv
// ----------------------------------------------------------------------------
// bswm_decode
// Splits one registered CPU word into bank-register and IRQ commands.
// ----------------------------------------------------------------------------
`default_nettype none

module bswm_decode
    import bswm_pkg::*;
(
    input  wire logic        i_op,
    input  wire logic [15:0] i_addr,
    input  wire logic [7:0]  i_data,
    output t_map_cmd         o_map_cmd,
    output t_irq_cmd         o_irq_cmd
);

    t_slot_dec  w_dec;
    logic [3:0] w_win;
    logic [3:0] w_chr_win;
    logic       w_wr;

    assign w_dec     = decode_slot(i_addr[11:0]);
    assign w_win     = i_addr[15:12];
    assign w_chr_win = w_win - WIN_CHR_FIRST;
    // windows below 8000 never hit
    assign w_wr      = (i_op == OP_WRITE) && i_addr[15] && w_dec.hit;

    always_comb begin
        o_map_cmd.prg_wr    = w_wr && (w_win == WIN_PRG);
        o_map_cmd.mirror_wr = w_wr && (w_win == WIN_CTL) && !w_dec.slot[0];
        o_map_cmd.swap_wr   = w_wr && (w_win == WIN_CTL) && w_dec.slot[0];
        o_map_cmd.a000_wr   = w_wr && (w_win == WIN_A000);
        o_map_cmd.chr_wr    = w_wr && (w_win >= WIN_CHR_FIRST) && (w_win <= WIN_CHR_LAST);
        o_map_cmd.chr_hi    = w_dec.slot[1];
        o_map_cmd.chr_idx   = {w_chr_win[1:0], w_dec.slot[0]};
        o_map_cmd.data      = i_data;

        o_irq_cmd.tick      = (i_op == OP_TICK);
        o_irq_cmd.reload_lo = w_wr && (w_win == WIN_IRQ) && (w_dec.slot == SLOT_0);
        o_irq_cmd.reload_hi = w_wr && (w_win == WIN_IRQ) && (w_dec.slot == SLOT_2);
        o_irq_cmd.ctrl      = w_wr && (w_win == WIN_IRQ) && (w_dec.slot == SLOT_1);
        o_irq_cmd.ack       = w_wr && (w_win == WIN_IRQ) && (w_dec.slot == SLOT_3);
        o_irq_cmd.data      = i_data;
    end

endmodule

`default_nettype wire

FILE: hdl/bswm_banks.sv
// ----------------------------------------------------------------------------
// bswm_banks
// PRG, CHR and mirroring registers; exports the post-write state.
// ----------------------------------------------------------------------------
`default_nettype none

module bswm_banks
    import bswm_pkg::*;
(
    input  wire logic i_clk,
    input  wire logic i_rst_n,
    input  wire logic i_step,
    input  t_map_cmd  i_cmd,
    output t_map_state o_next
);

    t_map_state r_map;
    t_map_state n_map;

    always_comb begin
        n_map = r_map;
        if (i_step) begin
            if (i_cmd.prg_wr) begin
                n_map.prg_select = i_cmd.data;
            end
            if (i_cmd.mirror_wr) begin
                n_map.mirror = i_cmd.data[1:0];
            end
            if (i_cmd.swap_wr) begin
                n_map.swap = i_cmd.data[1];
            end
            if (i_cmd.a000_wr) begin
                n_map.a000 = i_cmd.data[4:0];
            end
            if (i_cmd.chr_wr) begin
                if (i_cmd.chr_hi) begin
                    n_map.chr[i_cmd.chr_idx][7:4] = i_cmd.data[3:0];
                end else begin
                    n_map.chr[i_cmd.chr_idx][3:0] = i_cmd.data[3:0];
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_map            <= '0;
            r_map.a000       <= A000_RESET;
        end else begin
            r_map <= n_map;
        end
    end

    assign o_next = n_map;

endmodule

`default_nettype wire

FILE: hdl/bswm_irq.sv
// ----------------------------------------------------------------------------
// bswm_irq
// IRQ reload/control registers, scanline prescaler and 9-bit counter.
// ----------------------------------------------------------------------------
`default_nettype none

module bswm_irq
    import bswm_pkg::*;
(
    input  wire logic i_clk,
    input  wire logic i_rst_n,
    input  wire logic i_step,
    input  t_irq_cmd  i_cmd,
    output logic      o_next_pending
);

    logic [7:0]        r_reload;
    logic [8:0]        r_count;
    logic signed [9:0] r_presc;
    logic              r_cycle;
    logic              r_en;
    logic              r_eaa;
    logic              r_pending;

    logic [7:0]        n_reload;
    logic [8:0]        n_count;
    logic signed [9:0] n_presc;
    logic              n_cycle;
    logic              n_en;
    logic              n_eaa;
    logic              n_pending;

    logic [8:0]        w_cnt_inc;
    logic              w_fire;
    logic [8:0]        w_cnt_step;
    logic              w_presc_pos;

    // counter holds at 0x100 once past the fire value
    assign w_cnt_inc   = (r_count < COUNT_SAT) ? (r_count + 9'd1) : r_count;
    assign w_fire      = (w_cnt_inc == COUNT_FIRE);
    assign w_cnt_step  = w_fire ? {1'b0, r_reload} : w_cnt_inc;
    assign w_presc_pos = (r_presc > 10'sd0);

    always_comb begin
        n_reload  = r_reload;
        n_count   = r_count;
        n_presc   = r_presc;
        n_cycle   = r_cycle;
        n_en      = r_en;
        n_eaa     = r_eaa;
        n_pending = r_pending;
        if (i_step) begin
            if (i_cmd.tick) begin
                if (r_en) begin
                    if (r_cycle || !w_presc_pos) begin
                        n_count = w_cnt_step;
                        if (w_fire) begin
                            n_pending = 1'b1;
                        end
                        if (!r_cycle) begin
                            n_presc = PRESCALE_START;
                        end
                    end else begin
                        n_presc = r_presc - PRESCALE_STEP;
                    end
                end
            end else if (i_cmd.reload_lo) begin
                n_reload[3:0] = i_cmd.data[3:0];
            end else if (i_cmd.reload_hi) begin
                n_reload[7:4] = i_cmd.data[3:0];
            end else if (i_cmd.ctrl) begin
                n_cycle   = i_cmd.data[2];
                n_en      = i_cmd.data[1];
                n_eaa     = i_cmd.data[0];
                n_pending = 1'b0;
                if (i_cmd.data[1]) begin
                    n_count = {1'b0, r_reload};
                    n_presc = PRESCALE_START;
                end
            end else if (i_cmd.ack) begin
                n_pending = 1'b0;
                n_en      = r_eaa;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_reload  <= '0;
            r_count   <= '0;
            r_presc   <= PRESCALE_START;
            r_cycle   <= 1'b0;
            r_en      <= 1'b0;
            r_eaa     <= 1'b0;
            r_pending <= 1'b0;
        end else begin
            r_reload  <= n_reload;
            r_count   <= n_count;
            r_presc   <= n_presc;
            r_cycle   <= n_cycle;
            r_en      <= n_en;
            r_eaa     <= n_eaa;
            r_pending <= n_pending;
        end
    end

    assign o_next_pending = n_pending;

`ifndef NO_ASSERTIONS
    a_idle_tick: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_step && i_cmd.tick && !r_en)
        |=> ($stable(r_count) && $stable(r_presc) && $stable(r_pending)))
        else $error("disabled tick changed IRQ state");

    a_count_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= COUNT_SAT)
        else $error("IRQ counter above saturation value");

    a_presc_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_presc <= PRESCALE_START) && (r_presc >= PRESCALE_FLOOR))
        else $error("prescaler out of range");

    a_raise_on_tick: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(r_pending) |-> $past(i_step && i_cmd.tick))
        else $error("IRQ raised without a tick");
`endif

endmodule

`default_nettype wire
